[design/tfe_pkg.sv]
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared types and constants of the tagged field encoder.
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HDR_MAX   = 3;
  localparam int unsigned VBYTES    = VALUE_W / BYTE_W;

  localparam logic [ID_W-1:0] SMALL_ID_LIMIT = 16'd30;
  localparam logic [ID_W-1:0] MEDIUM_ID_MAX  = 16'd285;
  localparam logic [4:0]      MEDIUM_CODE    = 5'd30;
  localparam logic [4:0]      LARGE_CODE     = 5'd31;

  // One classified item: header and extension bytes, raw value, byte counts.
  typedef struct packed {
    logic [HDR_MAX-1:0][BYTE_W-1:0] hdr;
    logic [1:0]                     hdr_cnt_m1;
    logic [VALUE_W-1:0]             value;
    logic [3:0]                     total_m1;
  } tfe_desc_t;

endpackage

[design/tagged_field_encoder_unit.sv]
// ----------------------------------------------------------------------------
// tagged_field_encoder_unit
// Encodes a field id and a 64-bit value as a tagged run of bytes.
// ----------------------------------------------------------------------------
// Usage: the input side is a queue. An item (field id and value) is taken at
// a rising edge where in_push is high and in_full is low. The result side is
// a queue as well. While out_empty is low, out_byte and out_last show the
// oldest waiting byte of an encoded field, and it is taken at an edge where
// out_pop is high. Each item yields one header byte, zero to two id extension
// bytes and one to eight value bytes, least significant first; out_last marks
// the final byte of the field.
// Path: a taken item is written into the descriptor queue, then loaded into
// the serializer, whose first byte goes into the output register when the
// result side is free. Throughput: the serializer emits one byte per cycle
// while out_pop takes each byte, and fields follow each other without gaps.
// A descriptor queue of QUEUE_DEPTH entries lets new items be taken while an
// earlier one is still being serialized.
// Reset: synchronous and active low; it empties the queue, drops any field in
// flight and marks the output register empty.
// Stall: while out_pop is low the current byte holds; once the queue fills,
// in_full rises and stays high until the serializer frees an entry.
// ----------------------------------------------------------------------------
module tagged_field_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [tfe_pkg::ID_W-1:0]    in_field_id,
  input  logic [tfe_pkg::VALUE_W-1:0] in_field_value,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [tfe_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);
  import tfe_pkg::*;

  // Handshake between the front and the descriptor queue.
  logic      q_push;
  logic      q_full;
  tfe_desc_t q_push_desc;

  // Handshake between the descriptor queue and the serializer.
  logic      q_valid;
  logic      q_pop;
  tfe_desc_t q_pop_desc;

  // The front classifies the id range and finds the value byte count.
  tfe_front u_front (
    .in_push        (in_push),
    .in_full        (in_full),
    .in_field_id    (in_field_id),
    .in_field_value (in_field_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_desc         (q_push_desc)
  );

  // The queue decouples item acceptance from byte serialization.
  tfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_desc  (q_pop_desc)
  );

  // The back walks each descriptor, one byte per cycle if taken, to out_byte.
  tfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (q_pop_desc),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

[design/tfe_front.sv]
// ----------------------------------------------------------------------------
// tfe_front
// Accepts items and classifies them into byte descriptors for the queue.
// ----------------------------------------------------------------------------
module tfe_front (
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [tfe_pkg::ID_W-1:0]     in_field_id,
  input  logic [tfe_pkg::VALUE_W-1:0]  in_field_value,
  input  logic                         q_full,
  output logic                         q_push,
  output tfe_pkg::tfe_desc_t           q_desc
);
  import tfe_pkg::*;

  logic [2:0]      vlen_m1;
  logic [ID_W-1:0] large_ext;
  logic [ID_W-1:0] medium_ext;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // Index of the most significant nonzero value byte; zero for a zero value.
  always_comb begin
    vlen_m1 = 3'd0;
    for (int i = 1; i < VBYTES; i++) begin
      if (in_field_value[i*BYTE_W +: BYTE_W] != '0) begin
        vlen_m1 = 3'(i);
      end
    end
  end

  assign large_ext  = in_field_id - {11'd0, LARGE_CODE};
  assign medium_ext = in_field_id - {11'd0, MEDIUM_CODE};

  always_comb begin
    q_desc       = '0;
    q_desc.value = in_field_value;
    if (in_field_id < SMALL_ID_LIMIT) begin
      q_desc.hdr[0]     = {in_field_id[4:0], vlen_m1};
      q_desc.hdr_cnt_m1 = 2'd0;
    end else if (in_field_id > MEDIUM_ID_MAX) begin
      q_desc.hdr[0]     = {LARGE_CODE, vlen_m1};
      q_desc.hdr[1]     = large_ext[15:8];
      q_desc.hdr[2]     = large_ext[7:0];
      q_desc.hdr_cnt_m1 = 2'd2;
    end else begin
      q_desc.hdr[0]     = {MEDIUM_CODE, vlen_m1};
      q_desc.hdr[1]     = medium_ext[7:0];
      q_desc.hdr_cnt_m1 = 2'd1;
    end
    q_desc.total_m1 = {2'd0, q_desc.hdr_cnt_m1} + {1'b0, vlen_m1} + 4'd1;
  end

endmodule

[design/tfe_queue.sv]
// ----------------------------------------------------------------------------
// tfe_queue
// Short descriptor queue between the classifying front and the serializer.
// ----------------------------------------------------------------------------
module tfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tfe_pkg::tfe_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output tfe_pkg::tfe_desc_t pop_desc
);
  import tfe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tfe_desc_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign valid    = (cnt_r != '0);
  assign pop_desc = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[design/tfe_back.sv]
// ----------------------------------------------------------------------------
// tfe_back
// Serializes descriptors into an output register, one byte per cycle if taken.
// ----------------------------------------------------------------------------
module tfe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  tfe_pkg::tfe_desc_t          q_desc,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [tfe_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);
  import tfe_pkg::*;

  tfe_desc_t         cur_r;
  logic              cur_valid_r, cur_valid_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              advance, done, load;
  logic [3:0]        vidx;
  logic [BYTE_W-1:0] cur_byte;

  assign advance = cur_valid_r && (!out_valid_r || out_pop);
  assign done    = advance && (idx_r == cur_r.total_m1);
  assign load    = q_valid && (!cur_valid_r || done);
  assign q_pop   = load;

  assign vidx = idx_r - ({2'd0, cur_r.hdr_cnt_m1} + 4'd1);

  always_comb begin
    if (idx_r <= {2'd0, cur_r.hdr_cnt_m1}) begin
      cur_byte = cur_r.hdr[idx_r[1:0]];
    end else begin
      cur_byte = cur_r.value[vidx[2:0]*BYTE_W +: BYTE_W];
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (advance) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_desc;
    end
    if (advance) begin
      out_byte_r <= cur_byte;
      out_last_r <= (idx_r == cur_r.total_m1);
    end
  end

  assign out_empty = !out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

[design/tfe_checker.sv]
// ----------------------------------------------------------------------------
// tfe_checker
// Port-level checks of the tagged field encoder, bound to the top level.
// ----------------------------------------------------------------------------
module tfe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [tfe_pkg::BYTE_W-1:0]  out_byte,
  input logic                        out_last
);
  import tfe_pkg::*;

  // High while the next byte to be taken opens a new field.
  logic first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_pop && !out_empty) begin
      first_r <= out_last;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("outputs not idle after reset");

  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte) && $stable(out_last))
    else $error("waiting byte changed or vanished");

  a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    first_r && !out_empty |-> !out_last)
    else $error("field ended on its header byte");

  a_small_header_len: assert property (@(posedge clk) disable iff (!rst_n)
    first_r && !out_empty && out_pop && out_byte[7:3] != LARGE_CODE
      && out_byte[7:3] != MEDIUM_CODE && out_byte[2:0] == 3'd0
      |=> !out_empty && out_last)
    else $error("short field did not end after one value byte");

endmodule

bind tagged_field_encoder_unit tfe_checker u_tfe_checker (.*);
